@@ hdl/rws_pkg.sv @@
// Shared types and constants for the RIFF wave stream to samples core.
package rws_pkg;

  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [4:0]  FMT_BODY_BYTES = 5'd16;

  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_TRUNC     = 4'd1;
  localparam logic [3:0] ST_NO_RIFF   = 4'd2;
  localparam logic [3:0] ST_NO_WAVE   = 4'd3;
  localparam logic [3:0] ST_MISSING   = 4'd4;
  localparam logic [3:0] ST_BAD_META  = 4'd5;
  localparam logic [3:0] ST_BAD_FMT   = 4'd6;
  localparam logic [3:0] ST_BAD_ALIGN = 4'd7;
  localparam logic [3:0] ST_BAD_PCM   = 4'd8;
  localparam logic [3:0] ST_BAD_FLT   = 4'd9;
  localparam logic [3:0] ST_ORDER     = 4'd10;

  localparam logic [15:0] FMT_PCM   = 16'd1;
  localparam logic [15:0] FMT_FLOAT = 16'd3;

  typedef enum logic [11:0] {
    PH_RIFF       = 12'b0000_0000_0001,
    PH_RSIZE      = 12'b0000_0000_0010,
    PH_WAVE       = 12'b0000_0000_0100,
    PH_TAG        = 12'b0000_0000_1000,
    PH_SIZE_FMT   = 12'b0000_0001_0000,
    PH_SIZE_DATA  = 12'b0000_0010_0000,
    PH_SIZE_OTHER = 12'b0000_0100_0000,
    PH_FMT        = 12'b0000_1000_0000,
    PH_SKIP       = 12'b0001_0000_0000,
    PH_DATA       = 12'b0010_0000_0000,
    PH_PAD        = 12'b0100_0000_0000,
    PH_HALT       = 12'b1000_0000_0000
  } phase_t;

  // Format of a raw sample, which selects its conversion.
  typedef enum logic [2:0] {
    CV_PCM8, CV_PCM16, CV_PCM24, CV_PCM32, CV_F32, CV_F64
  } conv_t;

  // One queued job from the parser to the converter.
  typedef struct packed {
    logic        kind;
    conv_t       conv;
    logic [63:0] raw;
    logic [15:0] channel_index;
    logic [3:0]  status_code;
    logic [31:0] rate_hz;
    logic [15:0] channels;
    logic [15:0] sample_depth;
    logic [15:0] format_tag;
  } job_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] sample_bits;
    logic [15:0] channel_index;
    logic [3:0]  status_code;
    logic [31:0] rate_hz;
    logic [15:0] channels;
    logic [15:0] sample_depth;
    logic [15:0] format_tag;
  } result_t;

endpackage

@@ hdl/rws_parser.sv @@
// Byte parser: walks RIFF chunks and builds conversion jobs.
module rws_parser
  import rws_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] file_byte,
  input  logic       end_of_file,
  output logic       job_valid,
  input  logic       job_room,
  output job_t       job
);

  phase_t      phase, phase_next;
  logic [31:0] field_shift, field_shift_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [4:0]  fidx, fidx_next;
  logic        pad_pending, pad_pending_next;
  logic [15:0] format_seen, format_seen_next, channels_seen, channels_seen_next;
  logic [31:0] rate_seen, rate_seen_next;
  logic [15:0] align_seen, align_seen_next, depth_seen, depth_seen_next;
  logic        fmt_found, fmt_found_next, data_found, data_found_next;
  logic [63:0] gather, gather_next;
  logic [3:0]  sbc, sbc_next;
  logic [15:0] chan, chan_next;
  logic        err, err_next;
  logic [3:0]  err_code, err_code_next;
  logic [3:0]  fmt_code;
  logic [3:0]  fmt_code_r;
  logic [12:0] bps;
  logic [28:0] align_calc;
  logic [31:0] word, field_full;
  logic [63:0] gather_full;
  logic [3:0]  sbc_inc;
  logic        field_done;
  logic [3:0]  eof_code;
  conv_t       conv_sel;

  assign in_ready = job_room;
  wire take = in_valid && in_ready;

  assign bps = depth_seen[15:3];
  assign align_calc = 29'(bps) * 29'(channels_seen);
  assign word = {24'd0, file_byte} << {fidx[1:0], 3'b000};
  assign field_full = field_shift | word;
  assign field_done = (fidx[1:0] == 2'd3);
  assign gather_full = gather | ({56'd0, file_byte} << {sbc[2:0], 3'b000});
  assign sbc_inc = sbc + 4'd1;

  // Format verdict is registered so the data size path stays short.
  always_comb begin
    if (channels_seen == 16'd0 || rate_seen == 32'd0 || align_seen == 16'd0) begin
      fmt_code = ST_BAD_META;
    end else if (format_seen != FMT_PCM && format_seen != FMT_FLOAT) begin
      fmt_code = ST_BAD_FMT;
    end else if (bps == 13'd0 || align_calc != {13'd0, align_seen}) begin
      fmt_code = ST_BAD_ALIGN;
    end else if (format_seen == FMT_PCM && depth_seen != 16'd8 && depth_seen != 16'd16 &&
                 depth_seen != 16'd24 && depth_seen != 16'd32) begin
      fmt_code = ST_BAD_PCM;
    end else if (format_seen == FMT_FLOAT && depth_seen != 16'd32 && depth_seen != 16'd64) begin
      fmt_code = ST_BAD_FLT;
    end else begin
      fmt_code = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    fmt_code_r <= fmt_code;
  end

  always_comb begin
    conv_sel = CV_PCM32;
    if (format_seen == FMT_FLOAT) begin
      conv_sel = (depth_seen == 16'd32) ? CV_F32 : CV_F64;
    end else begin
      case (depth_seen)
        16'd8:   conv_sel = CV_PCM8;
        16'd16:  conv_sel = CV_PCM16;
        16'd24:  conv_sel = CV_PCM24;
        default: conv_sel = CV_PCM32;
      endcase
    end
  end

  always_comb begin
    if (err) begin
      eof_code = err_code;
    end else if (!((phase == PH_TAG && fidx == 5'd0) || phase == PH_PAD)) begin
      eof_code = ST_TRUNC;
    end else if (!fmt_found || !data_found) begin
      eof_code = ST_MISSING;
    end else begin
      eof_code = ST_OK;
    end
  end

  always_comb begin
    phase_next = phase;
    field_shift_next = field_shift;
    bytes_left_next = bytes_left;
    fidx_next = fidx;
    pad_pending_next = pad_pending;
    format_seen_next = format_seen;
    channels_seen_next = channels_seen;
    rate_seen_next = rate_seen;
    align_seen_next = align_seen;
    depth_seen_next = depth_seen;
    fmt_found_next = fmt_found;
    data_found_next = data_found;
    gather_next = gather;
    sbc_next = sbc;
    chan_next = chan;
    err_next = err;
    err_code_next = err_code;
    job_valid = 1'b0;
    job.kind = 1'b0;
    job.conv = conv_sel;
    job.raw = gather_full;
    job.channel_index = chan;
    job.status_code = ST_OK;
    job.rate_hz = rate_seen;
    job.channels = channels_seen;
    job.sample_depth = depth_seen;
    job.format_tag = format_seen;
    if (take && end_of_file) begin
      job_valid = 1'b1;
      job.kind = 1'b1;
      job.raw = 64'd0;
      job.channel_index = 16'd0;
      job.status_code = eof_code;
      phase_next = PH_RIFF;
      field_shift_next = 32'd0;
      bytes_left_next = 32'd0;
      fidx_next = 5'd0;
      pad_pending_next = 1'b0;
      format_seen_next = 16'd0;
      channels_seen_next = 16'd0;
      rate_seen_next = 32'd0;
      align_seen_next = 16'd0;
      depth_seen_next = 16'd0;
      fmt_found_next = 1'b0;
      data_found_next = 1'b0;
      gather_next = 64'd0;
      sbc_next = 4'd0;
      chan_next = 16'd0;
      err_next = 1'b0;
      err_code_next = ST_OK;
    end else if (take) begin
      case (phase)
        PH_RIFF, PH_RSIZE, PH_WAVE, PH_TAG, PH_SIZE_FMT, PH_SIZE_DATA, PH_SIZE_OTHER: begin
          field_shift_next = field_full;
          fidx_next = fidx + 5'd1;
          if (field_done) begin
            field_shift_next = 32'd0;
            fidx_next = 5'd0;
            case (phase)
              PH_RIFF: begin
                if (field_full != TAG_RIFF) begin
                  err_next = 1'b1; err_code_next = ST_NO_RIFF; phase_next = PH_HALT;
                end else begin
                  phase_next = PH_RSIZE;
                end
              end
              PH_RSIZE: phase_next = PH_WAVE;
              PH_WAVE: begin
                if (field_full != TAG_WAVE) begin
                  err_next = 1'b1; err_code_next = ST_NO_WAVE; phase_next = PH_HALT;
                end else begin
                  phase_next = PH_TAG;
                end
              end
              PH_TAG: begin
                if (field_full == TAG_FMT) begin
                  if (fmt_found) begin
                    err_next = 1'b1; err_code_next = ST_ORDER; phase_next = PH_HALT;
                  end else begin
                    phase_next = PH_SIZE_FMT;
                  end
                end else if (field_full == TAG_DATA) begin
                  if (!fmt_found || data_found) begin
                    err_next = 1'b1; err_code_next = ST_ORDER; phase_next = PH_HALT;
                  end else begin
                    phase_next = PH_SIZE_DATA;
                  end
                end else begin
                  phase_next = PH_SIZE_OTHER;
                end
              end
              default: begin
                pad_pending_next = field_full[0];
                bytes_left_next = field_full;
                if (phase == PH_SIZE_FMT) begin
                  if (field_full < 32'd16) begin
                    err_next = 1'b1; err_code_next = ST_BAD_META; phase_next = PH_HALT;
                  end else begin
                    phase_next = PH_FMT;
                  end
                end else if (phase == PH_SIZE_DATA) begin
                  if (fmt_code_r != ST_OK) begin
                    err_next = 1'b1; err_code_next = fmt_code_r; phase_next = PH_HALT;
                  end else begin
                    data_found_next = 1'b1;
                    gather_next = 64'd0;
                    sbc_next = 4'd0;
                    chan_next = 16'd0;
                    if (field_full == 32'd0) begin
                      phase_next = field_full[0] ? PH_PAD : PH_TAG;
                      pad_pending_next = 1'b0;
                    end else begin
                      phase_next = PH_DATA;
                    end
                  end
                end else begin
                  if (field_full == 32'd0) begin
                    phase_next = PH_TAG;
                    pad_pending_next = 1'b0;
                  end else begin
                    phase_next = PH_SKIP;
                  end
                end
              end
            endcase
          end
        end
        PH_FMT: begin
          case (fidx[3:0])
            4'd0:  format_seen_next[7:0] = file_byte;
            4'd1:  format_seen_next[15:8] = file_byte;
            4'd2:  channels_seen_next[7:0] = file_byte;
            4'd3:  channels_seen_next[15:8] = file_byte;
            4'd4:  rate_seen_next[7:0] = file_byte;
            4'd5:  rate_seen_next[15:8] = file_byte;
            4'd6:  rate_seen_next[23:16] = file_byte;
            4'd7:  rate_seen_next[31:24] = file_byte;
            4'd12: align_seen_next[7:0] = file_byte;
            4'd13: align_seen_next[15:8] = file_byte;
            4'd14: depth_seen_next[7:0] = file_byte;
            4'd15: depth_seen_next[15:8] = file_byte;
            default: ;
          endcase
          fidx_next = fidx + 5'd1;
          bytes_left_next = bytes_left - 32'd1;
          if (fidx + 5'd1 >= FMT_BODY_BYTES) begin
            fidx_next = 5'd0;
            fmt_found_next = 1'b1;
            if (bytes_left == 32'd1) begin
              phase_next = pad_pending ? PH_PAD : PH_TAG;
              pad_pending_next = 1'b0;
            end else begin
              phase_next = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          bytes_left_next = bytes_left - 32'd1;
          if (bytes_left == 32'd1) begin
            phase_next = pad_pending ? PH_PAD : PH_TAG;
            pad_pending_next = 1'b0;
          end
        end
        PH_DATA: begin
          gather_next = gather_full;
          sbc_next = sbc_inc;
          if ({9'd0, sbc_inc} >= bps) begin
            job_valid = 1'b1;
            chan_next = ({1'b0, chan} + 17'd1 >= {1'b0, channels_seen}) ? 16'd0 : chan + 16'd1;
            gather_next = 64'd0;
            sbc_next = 4'd0;
          end
          bytes_left_next = bytes_left - 32'd1;
          if (bytes_left == 32'd1) begin
            gather_next = 64'd0;
            sbc_next = 4'd0;
            phase_next = pad_pending ? PH_PAD : PH_TAG;
            pad_pending_next = 1'b0;
          end
        end
        PH_PAD: phase_next = PH_TAG;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_RIFF;
      field_shift <= 32'd0;
      bytes_left <= 32'd0;
      fidx <= 5'd0;
      pad_pending <= 1'b0;
      format_seen <= 16'd0;
      channels_seen <= 16'd0;
      rate_seen <= 32'd0;
      align_seen <= 16'd0;
      depth_seen <= 16'd0;
      fmt_found <= 1'b0;
      data_found <= 1'b0;
      gather <= 64'd0;
      sbc <= 4'd0;
      chan <= 16'd0;
      err <= 1'b0;
      err_code <= ST_OK;
    end else begin
      phase <= phase_next;
      field_shift <= field_shift_next;
      bytes_left <= bytes_left_next;
      fidx <= fidx_next;
      pad_pending <= pad_pending_next;
      format_seen <= format_seen_next;
      channels_seen <= channels_seen_next;
      rate_seen <= rate_seen_next;
      align_seen <= align_seen_next;
      depth_seen <= depth_seen_next;
      fmt_found <= fmt_found_next;
      data_found <= data_found_next;
      gather <= gather_next;
      sbc <= sbc_next;
      chan <= chan_next;
      err <= err_next;
      err_code <= err_code_next;
    end
  end

endmodule

@@ hdl/rws_fifo.sv @@
// Short job queue between the parser and the converter.
module rws_fifo
  import rws_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  job_t wr_data,
  output logic room,
  output logic rd_valid,
  input  logic rd_en,
  output job_t rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  job_t          mem [DEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   count;

  assign room = (count != (AW+1)'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wp <= (wp == AW'(DEPTH - 1)) ? '0 : wp + AW'(1);
      end
      if (rd_en) begin
        rp <= (rp == AW'(DEPTH - 1)) ? '0 : rp + AW'(1);
      end
      count <= count + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

endmodule

@@ hdl/rws_convert.sv @@
// Sample converter: turns raw samples into binary64 and holds the output register.
module rws_convert
  import rws_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    job_valid,
  output logic    job_take,
  input  job_t    job,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t result
);

  logic [63:0] bits;
  logic [31:0] ival;
  logic [5:0]  lz;
  logic [31:0] mag, norm;
  logic [10:0] ebias;
  logic [31:0] f;
  logic [22:0] fm, fmn;
  logic [4:0]  flz;
  logic [10:0] fe;

  assign job_take = job_valid && (!out_valid || out_ready);

  always_comb begin
    case (job.conv)
      CV_PCM8:  ival = {job.raw[7:0] ^ 8'h80, 24'd0};
      CV_PCM16: ival = {job.raw[15:0], 16'd0};
      CV_PCM24: ival = {job.raw[23:0], 8'd0};
      default:  ival = job.raw[31:0];
    endcase
  end

  // Signed 32-bit fraction scaled by 2^-31.
  always_comb begin
    mag = ival[31] ? (~ival + 32'd1) : ival;
    lz = 6'd32;
    for (int i = 0; i < 32; i++) begin
      if (mag[i]) lz = 6'(31 - i);
    end
    norm = mag << lz[4:0];
    ebias = 11'd1023 - 11'(lz);
  end

  always_comb begin
    f = job.raw[31:0];
    fm = f[22:0];
    flz = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (fm[i]) flz = 5'(22 - i);
    end
    fmn = 23'(fm << (flz + 5'd1));
    fe = 11'd896 - 11'(flz);
  end

  always_comb begin
    case (job.conv)
      CV_F64: bits = job.raw;
      CV_F32: begin
        if (f[30:23] == 8'hFF) begin
          bits = {f[31], 11'h7FF, (fm != 23'd0), fm[21:0], 29'd0};
        end else if (f[30:23] == 8'd0) begin
          bits = (fm == 23'd0) ? {f[31], 63'd0} : {f[31], fe, fmn, 29'd0};
        end else begin
          bits = {f[31], f[30], {3{~f[30]}}, f[29:23], fm, 29'd0};
        end
      end
      default: begin
        if (lz == 6'd32) begin
          bits = 64'd0;
        end else begin
          bits = {ival[31], ebias, norm[30:0], 21'd0};
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (job_take) begin
      result.kind <= job.kind;
      result.sample_bits <= job.kind ? 64'd0 : bits;
      result.channel_index <= job.channel_index;
      result.status_code <= job.status_code;
      result.rate_hz <= job.rate_hz;
      result.channels <= job.channels;
      result.sample_depth <= job.sample_depth;
      result.format_tag <= job.format_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (job_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ hdl/riff_wave_stream_to_samples_core.sv @@
// Top level of the RIFF wave stream to samples core.
//
// The slave channel takes one word per cycle while tready is high: tdata carries
// the next file byte and tuser marks end of file. The master channel returns one
// word for each complete sample and one status word per file, marked by tlast.
// When the parser accepts the last byte of a sample it writes a job into a
// four-entry queue, and the converter registers the binary64 result from the
// queue head into the output register. Sustained throughput is one byte per
// cycle while the queue has room, set by the parser's byte loop.
// The status word of a file ends the parse and the core starts on a new file.
// Samples are provisional until the status word reports ok.
// Reset clears the parser, the queue and the output register; no word is pending
// afterward. When the receiver stalls, results collect in the queue and the output
// register, and tready falls only once the queue has no room for another job.
module riff_wave_stream_to_samples_core
  import rws_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [7:0]   s_tdata,   // file_byte
  input  logic         s_tuser,   // end_of_file
  output logic         m_tvalid,
  input  logic         m_tready,
  // sample_bits[63:0], channel_index[79:64], status_code[83:80], rate_hz[115:84],
  // channels[131:116], sample_depth[147:132], format_tag[163:148], zero fill
  output logic [167:0] m_tdata,
  output logic         m_tuser,   // kind
  output logic         m_tlast    // last
);

  job_t    push_job, head_job;
  logic    push, room, head_valid, head_take;
  result_t res;

  rws_parser u_parser (
    .clk(clk), .rst(rst),
    .in_valid(s_tvalid), .in_ready(s_tready),
    .file_byte(s_tdata), .end_of_file(s_tuser),
    .job_valid(push), .job_room(room), .job(push_job)
  );

  rws_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk(clk), .rst(rst),
    .wr_en(push), .wr_data(push_job), .room(room),
    .rd_valid(head_valid), .rd_en(head_take), .rd_data(head_job)
  );

  rws_convert u_convert (
    .clk(clk), .rst(rst),
    .job_valid(head_valid), .job_take(head_take), .job(head_job),
    .out_valid(m_tvalid), .out_ready(m_tready), .result(res)
  );

  assign m_tdata = {4'd0, res.format_tag, res.sample_depth, res.channels, res.rate_hz,
                    res.status_code, res.channel_index, res.sample_bits};
  assign m_tuser = res.kind;
  assign m_tlast = res.kind;

endmodule

@@ hdl/rws_checker.sv @@
// Port checker for the RIFF wave stream to samples core, bound to the top level.
module rws_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [167:0] m_tdata,
  input logic         m_tuser,
  input logic         m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled output word changed.");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == m_tuser))
    else $error("Last flag does not match kind.");

  a_sample_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[83:80] == 4'd0)
    else $error("Sample word carries a status code.");

  a_status_bits: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[79:0] == 80'd0 && m_tdata[83:80] <= 4'd10)
    else $error("Status word has sample fields or bad code.");

  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Output valid right after reset.");

endmodule

bind riff_wave_stream_to_samples_core rws_checker u_rws_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
  .m_tuser(m_tuser), .m_tlast(m_tlast)
);
